/* hw/rtl/bfm_pkg.sv */
// ----------------------------------------------------------------------------
// bfm_pkg
// Types and constants for the radix-2 Booth fraction multiplier.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int FRAC_BITS = 8;
    localparam int PROD_BITS = 2 * FRAC_BITS;
    // accumulator wide enough for any signed fraction product plus headroom
    localparam int ACC_W     = 2 * FRAC_BITS + 2;
    localparam int CELLS     = FRAC_BITS + 1;

    // Booth pair codes {y[i], y[i-1]}
    localparam logic [1:0] PAIR_ADD = 2'b01;
    localparam logic [1:0] PAIR_SUB = 2'b10;

    typedef struct packed {
        logic                 multiplicand_sign;
        logic [FRAC_BITS-1:0] multiplicand_mag;
        logic                 multiplier_sign;
        logic [FRAC_BITS-1:0] multiplier_mag;
    } t_operand;

    typedef struct packed {
        logic                 product_sign;
        logic [PROD_BITS-1:0] product_mag;
    } t_result;

    // one beat moving down the cell chain
    typedef struct packed {
        logic                    vld;
        logic                    sign;
        logic                    zero;
        logic                    prev;
        logic [FRAC_BITS:0]      y;
        logic signed [ACC_W-1:0] xs;
        logic signed [ACC_W-1:0] acc;
    } t_stage;

endpackage

/* hw/rtl/bfm_cell.sv */
// ----------------------------------------------------------------------------
// bfm_cell
// One Booth step: add, subtract or skip the shifted multiplicand, then pass
// the beat on with multiplicand shifted left and multiplier shifted right.
// ----------------------------------------------------------------------------
module bfm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bfm_pkg::t_stage i_stage,
    output bfm_pkg::t_stage o_stage
);

    bfm_pkg::t_stage r_stage;
    logic signed [bfm_pkg::ACC_W-1:0] n_acc;

    always_comb begin
        case ({i_stage.y[0], i_stage.prev})
            bfm_pkg::PAIR_ADD: n_acc = i_stage.acc + i_stage.xs;
            bfm_pkg::PAIR_SUB: n_acc = i_stage.acc - i_stage.xs;
            default:           n_acc = i_stage.acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage.vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage.sign <= i_stage.sign;
        r_stage.zero <= i_stage.zero;
        r_stage.prev <= i_stage.y[0];
        r_stage.y    <= {1'b0, i_stage.y[bfm_pkg::FRAC_BITS:1]};
        r_stage.xs   <= i_stage.xs <<< 1;
        r_stage.acc  <= n_acc;
    end

    assign o_stage = r_stage;

endmodule

/* hw/rtl/booth_fraction_multiplier_unit.sv */
// ----------------------------------------------------------------------------
// booth_fraction_multiplier_unit
// Signed sign-magnitude fraction multiplier built as a chain of Booth cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_operand and pulse start; a beat is taken on any edge with start
//   high and busy low. busy stays low, so a new operand pair may enter on
//   every cycle.
//   Each result appears on o_result for one cycle with o_valid high, in the
//   order the operands went in; the receiver cannot stall the output.
//   A beat passes through the sign-magnitude to two's complement front-end
//   register, one register per Booth cell (FRAC_BITS+1 cells) and the
//   magnitude back-end register.
//   Throughput is one operand pair per cycle; each cell holds one beat.
//   Synchronous reset (i_rst_n low) drops all beats in flight; no results
//   are produced for them.
//   A zero operand magnitude yields a positive zero product.
// ----------------------------------------------------------------------------
module booth_fraction_multiplier_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bfm_pkg::t_operand i_operand,
    output logic              o_valid,
    output bfm_pkg::t_result  o_result
);

    localparam int F = bfm_pkg::FRAC_BITS;
    localparam int W = bfm_pkg::ACC_W;

    bfm_pkg::t_stage r_front;
    bfm_pkg::t_stage w_stage [bfm_pkg::CELLS+1];
    bfm_pkg::t_result r_result;
    logic r_valid;

    logic signed [W-1:0] n_x;
    logic [F:0]          n_y;
    logic signed [W-1:0] n_mag;

    assign busy = 1'b0;

    // front end: sign-magnitude to two's complement
    always_comb begin
        n_x = i_operand.multiplicand_sign
            ? -$signed({{(W-F){1'b0}}, i_operand.multiplicand_mag})
            :  $signed({{(W-F){1'b0}}, i_operand.multiplicand_mag});
        n_y = i_operand.multiplier_sign
            ? -{1'b0, i_operand.multiplier_mag}
            :  {1'b0, i_operand.multiplier_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.vld <= 1'b0;
        end else begin
            r_front.vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front.sign <= i_operand.multiplicand_sign ^ i_operand.multiplier_sign;
        r_front.zero <= (i_operand.multiplicand_mag == '0) ||
                        (i_operand.multiplier_mag == '0);
        r_front.prev <= 1'b0;
        r_front.y    <= n_y;
        r_front.xs   <= n_x;
        r_front.acc  <= '0;
    end

    assign w_stage[0] = r_front;

    for (genvar g = 0; g < bfm_pkg::CELLS; g++) begin : g_cell
        bfm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // back end: back to sign-magnitude
    assign n_mag = w_stage[bfm_pkg::CELLS].sign
                 ? -w_stage[bfm_pkg::CELLS].acc
                 :  w_stage[bfm_pkg::CELLS].acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_stage[bfm_pkg::CELLS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stage[bfm_pkg::CELLS].zero) begin
            r_result.product_sign <= 1'b0;
            r_result.product_mag  <= '0;
        end else begin
            r_result.product_sign <= w_stage[bfm_pkg::CELLS].sign;
            r_result.product_mag  <= n_mag[bfm_pkg::PROD_BITS-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_no_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.product_sign |-> o_result.product_mag != '0)
        else $error("negative zero product");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage[bfm_pkg::CELLS].vld && w_stage[bfm_pkg::CELLS].zero |=>
        o_valid && o_result.product_mag == '0 && !o_result.product_sign)
        else $error("zero operand gave nonzero product");

    a_y_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage[bfm_pkg::CELLS].vld |-> w_stage[bfm_pkg::CELLS].y == '0)
        else $error("multiplier bits left after last cell");

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage[bfm_pkg::CELLS].vld |=> o_valid)
        else $error("beat lost at back end");
`endif

endmodule

/* sim/tb_booth_fraction_multiplier_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_booth_fraction_multiplier_unit
// Self-checking bench for the Booth fraction multiplier. A directed set of
// corner operands is followed by random operand pairs with bursty input gaps.
// Each accepted beat is run through a local Booth recoding model and the
// product is checked in order against every o_valid beat.
// ----------------------------------------------------------------------------
module tb_booth_fraction_multiplier_unit;

    localparam int RANDOM_BEATS = 1030;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = bfm_pkg::FRAC_BITS + 12;
    localparam int CYCLE_LIMIT  = 60000;

    class product_scoreboard;
        localparam int WIDE = bfm_pkg::PROD_BITS + 4;

        bfm_pkg::t_result products_due[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // radix-2 Booth over the two's complement multiplier with a zero
        // bit appended below bit 0
        function bfm_pkg::t_result booth_product(bfm_pkg::t_operand op);
            logic signed [WIDE-1:0]      mcand;
            logic signed [WIDE-1:0]      acc;
            logic signed [WIDE-1:0]      mag;
            logic [bfm_pkg::FRAC_BITS:0] mplier;
            logic                        prev_bit;
            logic [1:0]                  pair;
            bfm_pkg::t_result            res;
            mcand = WIDE'(op.multiplicand_mag);
            if (op.multiplicand_sign) begin
                mcand = -mcand;
            end
            mplier = {1'b0, op.multiplier_mag};
            if (op.multiplier_sign) begin
                mplier = ~mplier + 1'b1;
            end
            acc      = '0;
            prev_bit = 1'b0;
            for (int i = 0; i <= bfm_pkg::FRAC_BITS; i++) begin
                pair = {mplier[i], prev_bit};
                if (pair == bfm_pkg::PAIR_ADD) begin
                    acc = acc + (mcand <<< i);
                end else if (pair == bfm_pkg::PAIR_SUB) begin
                    acc = acc - (mcand <<< i);
                end
                prev_bit = mplier[i];
            end
            if (op.multiplicand_mag == '0 || op.multiplier_mag == '0) begin
                res.product_sign = 1'b0;
                res.product_mag  = '0;
            end else begin
                res.product_sign = op.multiplicand_sign ^ op.multiplier_sign;
                mag              = res.product_sign ? -acc : acc;
                res.product_mag  = mag[bfm_pkg::PROD_BITS-1:0];
            end
            return res;
        endfunction

        function void note_operand(bfm_pkg::t_operand op);
            products_due.push_back(booth_product(op));
        endfunction

        task check_result(bfm_pkg::t_result got);
            bfm_pkg::t_result want;
            if (products_due.size() == 0) begin
                report_mismatch($sformatf("result %0d/%h with nothing pending",
                                          got.product_sign, got.product_mag));
            end else begin
                want = products_due.pop_front();
                if (got.product_sign !== want.product_sign) begin
                    report_mismatch($sformatf("product_sign %b, want %b",
                                              got.product_sign, want.product_sign));
                end
                if (got.product_mag !== want.product_mag) begin
                    report_mismatch($sformatf("product_mag %h, want %h",
                                              got.product_mag, want.product_mag));
                end
            end
        endtask

        function int pending();
            return products_due.size();
        endfunction
    endclass

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    bfm_pkg::t_operand i_operand = '0;
    logic              busy;
    logic              o_valid;
    bfm_pkg::t_result  o_result;

    product_scoreboard sb = new();
    int unsigned       cycle_count = 0;

    booth_fraction_multiplier_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_operand(i_operand),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // values read here are the ones the block saw at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_operand(i_operand);
            end
            if (o_valid) begin
                sb.check_result(o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("booth_fraction_multiplier_unit test failed");
            $finish;
        end
    end

    function automatic logic [bfm_pkg::FRAC_BITS-1:0] pick_mag();
        logic [bfm_pkg::FRAC_BITS-1:0] mag;
        case ($urandom_range(0, 15))
            0:       mag = '0;
            1:       mag = '1;
            2:       mag = bfm_pkg::FRAC_BITS'(1);
            3:       mag = {1'b1, {(bfm_pkg::FRAC_BITS-1){1'b0}}};
            default: mag = bfm_pkg::FRAC_BITS'($urandom);
        endcase
        return mag;
    endfunction

    function automatic bfm_pkg::t_operand rand_operand();
        bfm_pkg::t_operand op;
        op.multiplicand_sign = 1'($urandom_range(0, 1));
        op.multiplicand_mag  = pick_mag();
        op.multiplier_sign   = 1'($urandom_range(0, 1));
        op.multiplier_mag    = pick_mag();
        return op;
    endfunction

    function automatic bfm_pkg::t_operand make_operand(logic s1, int m1, logic s2, int m2);
        bfm_pkg::t_operand op;
        op.multiplicand_sign = s1;
        op.multiplicand_mag  = bfm_pkg::FRAC_BITS'(m1);
        op.multiplier_sign   = s2;
        op.multiplier_mag    = bfm_pkg::FRAC_BITS'(m2);
        return op;
    endfunction

    // start stays high on return so back-to-back beats need no extra edge
    task send_operand(bfm_pkg::t_operand op);
        start     <= 1'b1;
        i_operand <= op;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task idle_gap(int cycles);
        start     <= 1'b0;
        i_operand <= rand_operand();
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        bfm_pkg::t_operand corner[$];
        bit                gaps_on;
        int                wait_cycles;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zeros, negative zeros, full scale, single bits, alternating bits
        corner.push_back(make_operand(0, 0, 0, 0));
        corner.push_back(make_operand(1, 0, 1, 0));
        corner.push_back(make_operand(1, 0, 0, 200));
        corner.push_back(make_operand(0, 77, 1, 0));
        corner.push_back(make_operand(1, 255, 1, 0));
        corner.push_back(make_operand(0, 255, 0, 255));
        corner.push_back(make_operand(0, 255, 1, 255));
        corner.push_back(make_operand(1, 255, 0, 255));
        corner.push_back(make_operand(1, 255, 1, 255));
        corner.push_back(make_operand(0, 1, 0, 1));
        corner.push_back(make_operand(1, 1, 0, 1));
        corner.push_back(make_operand(1, 1, 1, 255));
        corner.push_back(make_operand(0, 255, 1, 1));
        corner.push_back(make_operand(0, 128, 0, 128));
        corner.push_back(make_operand(1, 128, 0, 128));
        corner.push_back(make_operand(1, 128, 1, 128));
        corner.push_back(make_operand(0, 170, 1, 85));
        corner.push_back(make_operand(1, 85, 0, 170));
        corner.push_back(make_operand(0, 170, 0, 170));
        corner.push_back(make_operand(1, 85, 1, 85));
        corner.push_back(make_operand(0, 127, 1, 129));
        corner.push_back(make_operand(1, 129, 0, 127));
        foreach (corner[k]) begin
            send_operand(corner[k]);
        end

        gaps_on = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) begin
                gaps_on = ($urandom_range(0, 9) < 7);
            end
            if (gaps_on && n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                idle_gap($urandom_range(1, 6));
            end
            send_operand(rand_operand());
        end
        start <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        wait_cycles = DRAIN_CYCLES;
        repeat (wait_cycles) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("booth_fraction_multiplier_unit test passed");
        end else begin
            $display("booth_fraction_multiplier_unit test failed");
        end
        $finish;
    end

endmodule
